// File: rtl/core/permutation_to_swaps_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the permutation to swaps unit
// Each macro expects a clock named clk and an active-low reset named arst_n.
// ----------------------------------------------------------------------------
`ifndef PERMUTATION_TO_SWAPS_UNIT_MACROS_SVH
`define PERMUTATION_TO_SWAPS_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PTS_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PTS_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/pts_pkg.sv
// ----------------------------------------------------------------------------
// pts_pkg
// Shared widths, constants and types of the permutation to swaps unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pts_pkg;

	// Width of a slot number on the ports.
	localparam int SLOT_W = 10;

	// Packed request widths, filled up to whole bytes.
	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 24;

	// Epoch tag stored with every table entry. Tag zero marks a cleared entry.
	localparam int EPOCH_W = 8;
	localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
	localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;

	// Top-level control states.
	typedef enum logic [1:0] {
		ST_CLEAR = 2'b01,
		ST_RUN   = 2'b10
	} state_t;

endpackage

// File: rtl/core/pts_ram.sv
// ----------------------------------------------------------------------------
// pts_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data. A read of the address being written returns the old contents.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pts_ram #(
	parameter int WIDTH = 18,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/core/permutation_to_swaps_unit.sv
// Pipeline: an accepted request passes through the request stage, which reads
// both tables, and then the output register. Only one request is in flight at a
// time, so each table's single write port can take the two writes of a swap.
// Reset: clears control state, then runs a clearing pass over all MAX_SLOTS entries with
// no request accepted; the same pass follows the end of every 255th permutation.
// ----------------------------------------------------------------------------
// permutation_to_swaps_unit
// Turns a permutation, one entry per request in slot order, into the swaps
// that realize it. Two tagged tables in RAM track where each original lies
// and which original each position holds; an epoch tag resets them to
// identity at the end of every permutation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module permutation_to_swaps_unit
	import pts_pkg::*;
#(
	parameter int MAX_SLOTS = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Input stream.
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // [9:0] wanted_slot, rest zero
	input  logic                  s_tlast,   // last
	// Output stream.
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // [0] swap_needed, [10:1] first_slot,
	                                         // [20:11] second_slot, rest zero
	output logic                  m_tlast    // end_of_run
);

	localparam int SW    = $clog2(MAX_SLOTS);
	localparam int ENT_W = EPOCH_W + SW;

	// Second write of a swap, held for the cycle after the first.
	typedef struct packed {
		logic [EPOCH_W-1:0] tag;
		logic [SW-1:0]      orig_addr;
		logic [SW-1:0]      orig_data;
		logic [SW-1:0]      pos_addr;
		logic [SW-1:0]      pos_data;
	} wr2_t;

	state_t             state_q;
	logic [SW-1:0]      clr_cnt_q;
	logic [EPOCH_W-1:0] epoch_q;
	logic [SW-1:0]      cur_q;

	logic               accept;
	logic [SW-1:0]      want_idx;
	logic               want_in_range;

	logic               s1_vld_s1;
	logic [SW-1:0]      want_s1;
	logic [SW-1:0]      here_s1;
	logic               rng_s1;
	logic               last_s1;
	logic               fwd_s1;

	wr2_t               wr2_q;
	logic               wr2_pend_q;

	logic [ENT_W-1:0]   pos_rdata;
	logic [ENT_W-1:0]   orig_rdata;
	logic [ENT_W-1:0]   pos_ent;
	logic [ENT_W-1:0]   orig_ent;
	logic [SW-1:0]      there;
	logic [SW-1:0]      displaced;
	logic               swap;
	logic               do_swap;

	logic               pos_we;
	logic [SW-1:0]      pos_waddr;
	logic [ENT_W-1:0]   pos_wdata;
	logic               orig_we;
	logic [SW-1:0]      orig_waddr;
	logic [ENT_W-1:0]   orig_wdata;

	logic               m_tvalid_q;
	logic               swap_q;
	logic [SW-1:0]      first_q;
	logic [SW-1:0]      second_q;
	logic               end_q;

	// Request handshake: one request in flight, and room in the output register.
	assign s_tready = (state_q == ST_RUN) && !s1_vld_s1 && (!m_tvalid_q || m_tready);
	assign accept   = s_tvalid && s_tready;

	assign want_idx      = SW'(s_tdata[SLOT_W-1:0]);
	assign want_in_range = 32'(s_tdata[SLOT_W-1:0]) < 32'(MAX_SLOTS);

	// Table memories.
	pts_ram #(
		.WIDTH(ENT_W),
		.DEPTH(MAX_SLOTS)
	) u_pos_ram (
		.clk  (clk),
		.we   (pos_we),
		.waddr(pos_waddr),
		.wdata(pos_wdata),
		.raddr(want_idx),
		.rdata(pos_rdata)
	);

	pts_ram #(
		.WIDTH(ENT_W),
		.DEPTH(MAX_SLOTS)
	) u_orig_ram (
		.clk  (clk),
		.we   (orig_we),
		.waddr(orig_waddr),
		.wdata(orig_wdata),
		.raddr(cur_q),
		.rdata(orig_rdata)
	);

	// Forward the second write of the previous swap when it hit the RAM in the
	// same cycle as this read, then fall back to identity for stale entries.
	always_comb begin
		pos_ent  = pos_rdata;
		orig_ent = orig_rdata;
		if (fwd_s1 && (wr2_q.pos_addr == want_s1)) begin
			pos_ent = {wr2_q.tag, wr2_q.pos_data};
		end
		if (fwd_s1 && (wr2_q.orig_addr == here_s1)) begin
			orig_ent = {wr2_q.tag, wr2_q.orig_data};
		end

		if (!rng_s1) begin
			there = here_s1;
		end else if (pos_ent[ENT_W-1 -: EPOCH_W] == epoch_q) begin
			there = pos_ent[SW-1:0];
		end else begin
			there = want_s1;
		end

		if (orig_ent[ENT_W-1 -: EPOCH_W] == epoch_q) begin
			displaced = orig_ent[SW-1:0];
		end else begin
			displaced = here_s1;
		end

		swap    = rng_s1 && (there != here_s1);
		do_swap = s1_vld_s1 && swap;
	end

	// Write port selection: clearing pass, second write, or first write.
	always_comb begin
		priority if (state_q == ST_CLEAR) begin
			pos_we     = 1'b1;
			pos_waddr  = clr_cnt_q;
			pos_wdata  = '0;
			orig_we    = 1'b1;
			orig_waddr = clr_cnt_q;
			orig_wdata = '0;
		end else if (wr2_pend_q) begin
			pos_we     = 1'b1;
			pos_waddr  = wr2_q.pos_addr;
			pos_wdata  = {wr2_q.tag, wr2_q.pos_data};
			orig_we    = 1'b1;
			orig_waddr = wr2_q.orig_addr;
			orig_wdata = {wr2_q.tag, wr2_q.orig_data};
		end else begin
			pos_we     = do_swap;
			pos_waddr  = want_s1;
			pos_wdata  = {epoch_q, here_s1};
			orig_we    = do_swap;
			orig_waddr = here_s1;
			orig_wdata = {epoch_q, want_s1};
		end
	end

	// Control state: clearing pass, epoch, slot counter and pipeline valids.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_cnt_q  <= '0;
			epoch_q    <= EPOCH_FIRST;
			cur_q      <= '0;
			s1_vld_s1  <= 1'b0;
			wr2_pend_q <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			s1_vld_s1  <= accept;
			wr2_pend_q <= do_swap;

			unique case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + SW'(1);
					if (clr_cnt_q == SW'(MAX_SLOTS - 1)) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (s1_vld_s1 && last_s1) begin
						if (epoch_q == EPOCH_LAST) begin
							epoch_q   <= EPOCH_FIRST;
							clr_cnt_q <= '0;
							state_q   <= ST_CLEAR;
						end else begin
							epoch_q <= epoch_q + EPOCH_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase

			if (accept) begin
				if (s_tlast || (cur_q == SW'(MAX_SLOTS - 1))) begin
					cur_q <= '0;
				end else begin
					cur_q <= cur_q + SW'(1);
				end
			end

			if (s1_vld_s1) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Request stage and second-write payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			want_s1 <= want_idx;
			here_s1 <= cur_q;
			rng_s1  <= want_in_range;
			last_s1 <= s_tlast;
			fwd_s1  <= wr2_pend_q;
		end
		if (do_swap) begin
			wr2_q.tag       <= epoch_q;
			wr2_q.orig_addr <= there;
			wr2_q.orig_data <= displaced;
			wr2_q.pos_addr  <= displaced;
			wr2_q.pos_data  <= there;
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (s1_vld_s1) begin
			swap_q   <= swap;
			first_q  <= here_s1;
			second_q <= there;
			end_q    <= last_s1;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {(OUT_DATA_W - 2 * SLOT_W - 1)'(0), SLOT_W'(second_q),
		SLOT_W'(first_q), swap_q};
	assign m_tlast  = end_q;

	// Checks.
	`include "permutation_to_swaps_unit_macros.svh"

	`PTS_ASSERT_NEXT(a_result_follows, s1_vld_s1, m_tvalid,
		"request in flight produced no result in the next cycle")
	`PTS_ASSERT_NOW(a_no_accept_in_clear, state_q == ST_CLEAR, !s_tready,
		"request accepted during the clearing pass")
	`PTS_ASSERT_NOW(a_write_ports_free, wr2_pend_q, !s1_vld_s1,
		"second swap write collides with a new swap")

endmodule

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for permutation_to_swaps_unit. Permutations go in one
// entry per request: hand-picked runs, then random well-formed permutations
// mixed with runs that repeat or scatter entries, and one run that passes the
// last slot. A predictor keeps its own copy of both position tables and the
// slot counter, and every result is compared field by field with the oldest
// prediction. Sender gaps and receiver stalls change from phase to phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
	import pts_pkg::*;

	localparam int SLOT_COUNT     = 1024;
	localparam int WATCHDOG_LIMIT = 6000;
	localparam int PRINT_LIMIT    = 100;

	typedef logic [SLOT_W-1:0] slot_t;

	typedef struct packed {
		logic  swap_needed;
		slot_t first_slot;
		slot_t second_slot;
		logic  end_of_run;
	} swap_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;   // [9:0] wanted_slot, rest zero
	logic                  s_tlast = 1'b0; // last
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;        // [0] swap_needed, [10:1] first_slot,
	                                       // [20:11] second_slot, rest zero
	logic                  m_tlast;        // end_of_run

	// Predictor state: where each original lies and what each position holds.
	slot_t        where_is [SLOT_COUNT];
	slot_t        held_at [SLOT_COUNT];
	slot_t        slot_now;
	swap_result_t pending_swaps[$];

	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;
	int error_count = 0;
	int entries_sent = 0;
	int runs_sent = 0;
	int swaps_predicted = 0;
	int results_seen = 0;
	int idle_cycles = 0;

	permutation_to_swaps_unit #(
		.MAX_SLOTS(SLOT_COUNT)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// Clock with a 10 ns period.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Both tables go back to identity after reset and after every last entry.
	function automatic void restore_identity();
		for (int n = 0; n < SLOT_COUNT; n++) begin
			where_is[n] = slot_t'(n);
			held_at[n]  = slot_t'(n);
		end
		slot_now = '0;
	endfunction

	// Works out the swap for one entry and moves the predicted tables along.
	function automatic swap_result_t predict_swap(slot_t wanted, logic last);
		swap_result_t r;
		slot_t        here;
		slot_t        there;
		slot_t        displaced;
		here = slot_now;
		there = here;
		r.swap_needed = 1'b0;
		if (int'(wanted) < SLOT_COUNT) begin
			there = where_is[wanted];
			if (there != here) begin
				displaced = held_at[here];
				r.swap_needed = 1'b1;
				held_at[here] = wanted;
				held_at[there] = displaced;
				where_is[wanted] = here;
				where_is[displaced] = there;
			end
		end
		r.first_slot = here;
		r.second_slot = there;
		r.end_of_run = last;
		if (last)
			restore_identity();
		else
			slot_now = (int'(here) == SLOT_COUNT - 1) ? slot_t'(0) : slot_t'(here + 1'b1);
		return r;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		if (error_count < PRINT_LIMIT)
			$display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
		error_count++;
	endtask

	// Sends one entry, records its prediction, then idles as the phase asks.
	task automatic send_entry(slot_t wanted, logic last);
		int           gap;
		swap_result_t predicted;
		gap = 0;
		s_tvalid <= 1'b1;
		s_tdata <= IN_DATA_W'(wanted);
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		predicted = predict_swap(wanted, last);
		pending_swaps.insert(pending_swaps.size(), predicted);
		if (predicted.swap_needed)
			swaps_predicted++;
		entries_sent++;
		while ($urandom_range(99) < sender_idle_pct && gap < 40)
			gap++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Sends a whole run, marking its final entry as last.
	task automatic send_run(slot_t entries[$]);
		foreach (entries[i])
			send_entry(entries[i], i == entries.size() - 1);
		runs_sent++;
	endtask

	task automatic make_shuffle(int n, output slot_t entries[$]);
		slot_t tmp;
		int    j;
		entries = {};
		for (int i = 0; i < n; i++)
			entries.insert(entries.size(), slot_t'(i));
		for (int i = n - 1; i > 0; i--) begin
			j = $urandom_range(i);
			tmp = entries[i];
			entries[i] = entries[j];
			entries[j] = tmp;
		end
	endtask

	task automatic set_idling(int sender_pct, int receiver_pct);
		sender_idle_pct = sender_pct;
		receiver_stall_pct = receiver_pct;
	endtask

	// Hand-picked runs: single entries, identity, reversal, repeats, extremes.
	task automatic test_directed_cases();
		send_run('{10'd0});
		send_run('{10'd1023});
		send_run('{10'd0, 10'd1, 10'd2});
		send_run('{10'd3, 10'd2, 10'd1, 10'd0});
		send_run('{10'd1023, 10'd0, 10'd1023});
		send_run('{10'd5, 10'd5});
		send_run('{10'd1, 10'd0});
		send_run('{10'd682, 10'd341});
	endtask

	// Mostly short well-formed permutations; some runs repeat or scatter entries.
	task automatic test_random_permutations(int target);
		slot_t entries[$];
		int    stop_at;
		int    pick;
		int    n;
		stop_at = entries_sent + target;
		while (entries_sent < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 70) begin
				n = ($urandom_range(9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
				make_shuffle(n, entries);
			end else if (pick < 85) begin
				n = $urandom_range(2, 8);
				make_shuffle(n, entries);
				entries[$urandom_range(n - 1)] = entries[$urandom_range(n - 1)];
			end else begin
				n = $urandom_range(1, 8);
				entries = {};
				repeat (n)
					entries.insert(entries.size(), slot_t'($urandom_range(SLOT_COUNT - 1)));
			end
			send_run(entries);
		end
	endtask

	// A full permutation of every slot, then a few more entries past the top.
	task automatic test_slot_counter_wrap();
		slot_t entries[$];
		make_shuffle(SLOT_COUNT, entries);
		repeat (6)
			entries.insert(entries.size(), slot_t'($urandom_range(SLOT_COUNT - 1)));
		send_run(entries);
	endtask

	// Receiver stalls at random with the phase's rate.
	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= receiver_stall_pct);

	// Each accepted result against the oldest prediction.
	always @(posedge clk) begin
		swap_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (pending_swaps.size() == 0) begin
				report_mismatch("result with none expected, first_slot", m_tdata[10:1], -1);
			end else begin
				want = pending_swaps.pop_front();
				if (m_tdata[0] !== want.swap_needed)
					report_mismatch("swap_needed", m_tdata[0], want.swap_needed);
				if (m_tdata[10:1] !== want.first_slot)
					report_mismatch("first_slot", m_tdata[10:1], want.first_slot);
				if (m_tdata[20:11] !== want.second_slot)
					report_mismatch("second_slot", m_tdata[20:11], want.second_slot);
				if (m_tlast !== want.end_of_run)
					report_mismatch("end_of_run", m_tlast, want.end_of_run);
			end
		end
	end

	// Ends the run if no request moves on either side for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Watchdog: no request accepted for %0d cycles", WATCHDOG_LIMIT);
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	initial begin
		restore_identity();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_idling(0, 0);
		test_directed_cases();
		set_idling(0, 0);
		test_random_permutations(190);
		set_idling(69, 0);
		test_random_permutations(190);
		set_idling(0, 69);
		test_random_permutations(190);
		set_idling(26, 26);
		test_random_permutations(190);
		test_slot_counter_wrap();
		s_tvalid <= 1'b0;

		while (pending_swaps.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		$display("Sent %0d entries in %0d permutations; %0d results checked, %0d swaps.",
			entries_sent, runs_sent, results_seen, swaps_predicted);
		$display("Runs included repeats, scattered slots, a counter wrap and %0d table epochs.",
			runs_sent / 255);
		if (error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
